@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the weight evaluator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// Check that a condition implies another in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

@@ rtl/gcwe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GF(4) code weight evaluator package
// Payload types, control codes, tracker interface structs and GF(4) product.
// ----------------------------------------------------------------------------
package gcwe_pkg;

   // Fixed field widths
   localparam int ROW_INDEX_W   = 3;
   localparam int ROW_SYMBOLS_W = 44;
   localparam int CFG_W         = 5;
   localparam int MIN_OUT_W     = 5;
   localparam int COUNT_W       = 12;

   localparam logic [COUNT_W-1:0]   COUNT_MAX   = {COUNT_W{1'b1}};
   localparam logic [MIN_OUT_W-1:0] MIN_OUT_MAX = {MIN_OUT_W{1'b1}};

   localparam logic [CFG_W-1:0] TARGET_WEIGHT_RESET = 5'd12;
   localparam logic [CFG_W-1:0] ABORT_BELOW_RESET   = 5'd10;

   // Extra-row multiplier range
   localparam logic [1:0] MUL_FIRST = 2'd1;
   localparam logic [1:0] MUL_LAST  = 2'd3;

   typedef enum logic {
      CSR_TARGET_WEIGHT = 1'b0,
      CSR_ABORT_BELOW   = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BUILD,
      ST_WALK,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [ROW_INDEX_W-1:0]   row_index;
      logic [ROW_SYMBOLS_W-1:0] row_symbols;
      logic                     start_req;
   } req_type;

   typedef struct packed {
      logic [MIN_OUT_W-1:0] min_weight;
      logic [COUNT_W-1:0]   weight_count;
      logic                 aborted;
   } rsp_type;

   // Sequencer to weight tracker
   typedef struct packed {
      logic clear;
      logic valid;
      logic walk;
   } track_ctrl_type;

   // Weight tracker to sequencer
   typedef struct packed {
      logic    busy;
      logic    stop;
      rsp_type result;
   } track_status_type;

   // GF(4) product, w = 2 and w^2 = 3
   localparam logic [1:0] GF_MUL [4][4] = '{
      '{2'd0, 2'd0, 2'd0, 2'd0},
      '{2'd0, 2'd1, 2'd2, 2'd3},
      '{2'd0, 2'd2, 2'd3, 2'd1},
      '{2'd0, 2'd3, 2'd1, 2'd2}
   };

   function automatic logic [1:0] gf_mul(logic [1:0] c, logic [1:0] s);
      return GF_MUL[c][s];
   endfunction

endpackage

@@ rtl/gcwe_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one generator row write per request.
// ----------------------------------------------------------------------------
interface gcwe_req_if;
   import gcwe_pkg::*;

   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/gcwe_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one evaluation result.
// ----------------------------------------------------------------------------
interface gcwe_rsp_if;
   import gcwe_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/gcwe_codeword_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Codeword memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gcwe_codeword_ram #(
   parameter int WIDTH  = 44,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [1 << ADDR_W];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/gcwe_weight_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weight tracker
// Two-stage weight unit: symbol count, then running minimum, target counts
// and abort flag.
// ----------------------------------------------------------------------------
module gcwe_weight_tracker #(
   parameter int CODE_LENGTH = 22
) (
   input  logic                           clock,
   input  logic                           reset,
   input  gcwe_pkg::track_ctrl_type       ctrl,
   input  logic [2*CODE_LENGTH-1:0]       word,
   input  logic [gcwe_pkg::CFG_W-1:0]     target_weight,
   input  logic [gcwe_pkg::CFG_W-1:0]     abort_below,
   output gcwe_pkg::track_status_type     status
);
   import gcwe_pkg::*;

   localparam int WW = $clog2(CODE_LENGTH + 2);
   localparam int CW = (WW > CFG_W) ? WW : CFG_W;
   localparam logic [WW-1:0] MIN_INIT = WW'(CODE_LENGTH + 1);

   logic [WW-1:0]      weight_sum;
   logic               a_valid_ff;
   logic               a_walk_ff;
   logic [WW-1:0]      weight_ff;
   logic [WW-1:0]      min_ff;
   logic [WW-1:0]      new_min;
   logic               hit;
   logic [COUNT_W-1:0] ext_cnt_ff;
   logic [COUNT_W-1:0] base_cnt_ff;
   logic               stop_ff;
   logic [COUNT_W:0]   total;

   function automatic logic [COUNT_W-1:0] sat_inc(logic [COUNT_W-1:0] v);
      return (v == COUNT_MAX) ? v : v + 1'b1;
   endfunction

   // Count nonzero symbols
   always_comb begin
      weight_sum = '0;
      for (int j = 0; j < CODE_LENGTH; j++) begin
         weight_sum = weight_sum + WW'(|word[2*j +: 2]);
      end
   end

   // Stage A: register the weight
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= ctrl.valid && !ctrl.clear;
      end
      a_walk_ff <= ctrl.walk;
      weight_ff <= weight_sum;
   end

   assign new_min = (weight_ff < min_ff) ? weight_ff : min_ff;
   assign hit     = (CW'(weight_ff) == CW'(target_weight));

   // Stage B: update minimum and counts, drop words after an abort
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff      <= '0;
         ext_cnt_ff  <= '0;
         base_cnt_ff <= '0;
         stop_ff     <= 1'b0;
      end else if (ctrl.clear) begin
         min_ff      <= MIN_INIT;
         ext_cnt_ff  <= '0;
         base_cnt_ff <= '0;
         stop_ff     <= 1'b0;
      end else if (a_valid_ff && !stop_ff) begin
         min_ff <= new_min;
         if (a_walk_ff) begin
            if (hit) begin
               ext_cnt_ff <= sat_inc(ext_cnt_ff);
            end
            if (CW'(new_min) < CW'(abort_below)) begin
               stop_ff <= 1'b1;
            end
         end else if (hit) begin
            base_cnt_ff <= sat_inc(base_cnt_ff);
         end
      end
   end

   // Combine the counts, saturating
   assign total = {1'b0, ext_cnt_ff} + {1'b0, base_cnt_ff};

   always_comb begin
      status.busy = a_valid_ff;
      status.stop = stop_ff;
      status.result.min_weight = (int'(min_ff) > int'(MIN_OUT_MAX)) ?
                                 MIN_OUT_MAX : MIN_OUT_W'(min_ff);
      if (stop_ff) begin
         status.result.weight_count = '0;
      end else if (total[COUNT_W]) begin
         status.result.weight_count = COUNT_MAX;
      end else begin
         status.result.weight_count = total[COUNT_W-1:0];
      end
      status.result.aborted = stop_ff;
   end

endmodule

@@ rtl/gf4_code_weight_evaluator.sv @@
`timescale 1ns / 1ps
// A request without start only writes its generator row. With start, the
// result is ready after the build, walk and drain phases, earlier on
// abort. One codeword is handled per cycle, set by the single read port of
// the codeword memory. Synchronous reset clears control state and sets the
// registers to 12 and 10; generator rows and codewords are not cleared.
// ----------------------------------------------------------------------------
// GF(4) code weight evaluator
// Builds all base codewords in memory, then walks them against the scaled
// extra row, tracking minimum weight and target weight count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gf4_code_weight_evaluator #(
   parameter int CODE_LENGTH = 22,
   parameter int BASE_ROWS   = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   gcwe_req_if.sink                      req_channel,
   gcwe_rsp_if.source                    rsp_channel,
   input  logic                          csr_write_enable,
   input  gcwe_pkg::csr_index_type       csr_index,
   input  logic [gcwe_pkg::CFG_W-1:0]    csr_data
);
   import gcwe_pkg::*;

   localparam int ROW_COUNT = BASE_ROWS + 1;
   localparam int ROW_W     = 2 * CODE_LENGTH;
   localparam int IW        = 2 * BASE_ROWS;
   localparam int RW        = $clog2(ROW_COUNT);
   localparam int EXT_W     = (ROW_W > ROW_SYMBOLS_W) ? ROW_W : ROW_SYMBOLS_W;
   localparam int IDX_W     = (RW > ROW_INDEX_W) ? RW : ROW_INDEX_W;
   localparam logic [IW-1:0] IDX_LAST  = {IW{1'b1}};
   localparam logic [RW-1:0] EXTRA_ROW = RW'(BASE_ROWS);

   // Configuration
   logic [CFG_W-1:0] target_weight_ff;
   logic [CFG_W-1:0] abort_below_ff;

   // Generator rows
   logic [ROW_W-1:0] rows_ff [ROW_COUNT];
   logic [EXT_W-1:0] field_ext;
   logic [IDX_W-1:0] row_idx_ext;
   logic             req_fire;

   // Sequencer
   state_type     state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [1:0]    mul_ff, mul_in;
   logic          issue;
   logic          clear;
   logic          rsp_load;
   logic          walk;

   // Issue stage
   logic [RW-1:0]    top_r;
   logic [1:0]       top_d;
   logic [IW-1:0]    src_idx;
   logic [IW-1:0]    rd_addr;
   logic [ROW_W-1:0] sel_row;
   logic [1:0]       sel_coef;
   logic [ROW_W-1:0] scaled;

   // Memory stage
   logic             s1_valid_ff;
   logic             s1_walk_ff;
   logic             s1_zero_ff;
   logic             s1_counted_ff;
   logic [IW-1:0]    s1_idx_ff;
   logic [ROW_W-1:0] s1_scaled_ff;
   logic [ROW_W-1:0] rd_data;
   logic [ROW_W-1:0] word1;
   logic             ram_wr_en;

   track_ctrl_type   trk_ctrl;
   track_status_type trk_status;

   // Response register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   // Check terms
   logic pipe_empty;
   logic rsp_abort;
   logic rsp_count_zero;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         target_weight_ff <= TARGET_WEIGHT_RESET;
         abort_below_ff   <= ABORT_BELOW_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TARGET_WEIGHT: target_weight_ff <= csr_data;
            CSR_ABORT_BELOW:   abort_below_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Store the row of each accepted request; symbols past the field read zero
   assign req_fire    = req_channel.valid && req_channel.ready;
   assign field_ext   = EXT_W'(req_channel.payload.row_symbols);
   assign row_idx_ext = IDX_W'(req_channel.payload.row_index);

   always_ff @(posedge clock) begin
      if (req_fire && (int'(req_channel.payload.row_index) < ROW_COUNT)) begin
         rows_ff[row_idx_ext[RW-1:0]] <= field_ext[ROW_W-1:0];
      end
   end

   // State register and walk counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         mul_ff   <= MUL_FIRST;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         mul_ff   <= mul_in;
      end
   end

   // Next state: build base words, walk the extra-row multiples, drain, deliver
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      mul_in   = mul_ff;
      issue    = 1'b0;
      clear    = 1'b0;
      rsp_load = 1'b0;
      req_channel.ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_channel.ready = 1'b1;
            if (req_channel.valid && req_channel.payload.start_req) begin
               clear    = 1'b1;
               idx_in   = '0;
               state_in = ST_BUILD;
            end
         end
         ST_BUILD: begin
            issue  = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IDX_LAST) begin
               mul_in   = MUL_FIRST;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (trk_status.stop) begin
               state_in = ST_DRAIN;
            end else begin
               issue  = 1'b1;
               idx_in = idx_ff + 1'b1;
               if (idx_ff == IDX_LAST) begin
                  if (mul_ff == MUL_LAST) begin
                     state_in = ST_DRAIN;
                  end else begin
                     mul_in = mul_ff + 1'b1;
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (!s1_valid_ff && !trk_status.busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_channel.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign walk = (state_ff == ST_WALK);

   // Find the highest nonzero digit; the base word without it is the source
   always_comb begin
      top_r = '0;
      top_d = '0;
      for (int r = 0; r < BASE_ROWS; r++) begin
         if (idx_ff[2*r +: 2] != 2'd0) begin
            top_r = RW'(r);
            top_d = idx_ff[2*r +: 2];
         end
      end
      src_idx = idx_ff & ~(IW'(3) << (2 * top_r));
   end

   // Select the row to add and scale it symbol by symbol
   always_comb begin
      sel_row  = walk ? rows_ff[EXTRA_ROW] : rows_ff[top_r];
      sel_coef = walk ? mul_ff : top_d;
      for (int j = 0; j < CODE_LENGTH; j++) begin
         scaled[2*j +: 2] = gf_mul(sel_coef, sel_row[2*j +: 2]);
      end
   end

   assign rd_addr = walk ? idx_ff : src_idx;

   // Issue stage to memory stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue;
      end
      s1_walk_ff    <= walk;
      s1_zero_ff    <= !walk && (src_idx == '0);
      s1_counted_ff <= walk || (idx_ff != '0);
      s1_idx_ff     <= idx_ff;
      s1_scaled_ff  <= scaled;
   end

   // Build writes entry b from an entry at least four below it, or from the
   // zero word, so the read always sees the finished value
   assign word1     = (s1_zero_ff ? '0 : rd_data) ^ s1_scaled_ff;
   assign ram_wr_en = s1_valid_ff && !s1_walk_ff;

   gcwe_codeword_ram #(
      .WIDTH  (ROW_W),
      .ADDR_W (IW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_idx_ff),
      .wr_data (word1),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign trk_ctrl.clear = clear;
   assign trk_ctrl.valid = s1_valid_ff && s1_counted_ff;
   assign trk_ctrl.walk  = s1_walk_ff;

   gcwe_weight_tracker #(
      .CODE_LENGTH (CODE_LENGTH)
   ) u_tracker (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (trk_ctrl),
      .word          (word1),
      .target_weight (target_weight_ff),
      .abort_below   (abort_below_ff),
      .status        (trk_status)
   );

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_channel.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= trk_status.result;
      end
   end

   assign rsp_channel.valid   = rsp_valid_ff;
   assign rsp_channel.payload = rsp_data_ff;

   // Checks
   assign pipe_empty     = !s1_valid_ff && !trk_status.busy;
   assign rsp_abort      = rsp_valid_ff && rsp_data_ff.aborted;
   assign rsp_count_zero = (rsp_data_ff.weight_count == '0);

   `ASSERT_IMPLIES(a_ready_pipe_empty, clock, reset, req_channel.ready, pipe_empty)
   `ASSERT_IMPLIES(a_abort_zero_count, clock, reset, rsp_abort, rsp_count_zero)
   `ASSERT_NEXT(a_clear_starts_build, clock, reset, clear, (state_ff == ST_BUILD) && !trk_status.stop)

endmodule
